>>> design/sdsd_pkg.sv
// shared types and constants of the screen dirty span diff block
`default_nettype none

package sdsd_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_CLEAR    = 2'd1,
        CMD_SNAPSHOT = 2'd2,
        CMD_DIFF     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_SNAP,
        ST_DIFF,
        ST_FLUSH
    } state_t;

    // one character cell as stored, compared as a whole
    typedef struct packed {
        logic [15:0] attributes;
        logic [1:0]  glyph_width;
        logic [20:0] glyph;
        logic [31:0] bg_colour;
        logic [31:0] fg_colour;
    } cell_t;

    localparam logic [20:0] BLANK_GLYPH = 21'h20;
    localparam logic [1:0]  BLANK_WIDTH = 2'd1;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic REG_ROWS_USED = 1'b0;
    localparam logic REG_COLS_USED = 1'b1;

    localparam logic [6:0] ROWS_USED_RESET = 7'd24;
    localparam logic [7:0] COLS_USED_RESET = 8'd80;

endpackage

`default_nettype wire

>>> design/sdsd_ifs.sv
// command and span channel interfaces
`default_nettype none

interface sdsd_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [5:0]  row;
    logic [6:0]  col;
    logic [20:0] glyph;
    logic [1:0]  glyph_width;
    logic [31:0] fg_colour;
    logic [31:0] bg_colour;
    logic [15:0] attributes;

    modport source (
        output valid, cmd, row, col, glyph, glyph_width, fg_colour, bg_colour, attributes,
        input  ready
    );
    modport sink (
        input  valid, cmd, row, col, glyph, glyph_width, fg_colour, bg_colour, attributes,
        output ready
    );
endinterface

interface sdsd_span_if;
    logic       valid;
    logic       ready;
    logic [5:0] span_row;
    logic [6:0] span_start;
    logic [7:0] span_end;
    logic       span_valid;
    logic       last;

    modport source (
        output valid, span_row, span_start, span_end, span_valid, last,
        input  ready
    );
    modport sink (
        input  valid, span_row, span_start, span_end, span_valid, last,
        output ready
    );
endinterface

`default_nettype wire

>>> design/screen_dirty_span_diff.sv
// Screen dirty span diff: two character-cell frames (current and previous) held in two
// synchronous single-port-write memories of MAX_ROWS * 2**clog2(MAX_COLS) cells each.
// After reset the block runs a clearing pass that zeroes both frames, one cell per
// cycle, and accepts no command until it is done; configuration writes are taken
// throughout. A cell write goes into the current frame and keeps the block idle.
// Clear and snapshot sweep the whole store one cell per cycle, snapshot reading the
// current frame and writing each cell into the previous one in the cycle after it is
// read. A row diff reads one column per cycle from both frames, but pauses while a
// closed span waits for the span channel to take the older one. Each result leaves
// through an output register, so the next command is taken while the last word waits.
`default_nettype none

module screen_dirty_span_diff #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    sdsd_cmd_if.sink                        command,
    sdsd_span_if.source                     span,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sdsd_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [sdsd_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [sdsd_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);

    import sdsd_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = MAX_ROWS * (2 ** COL_W);

    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);
    localparam logic [7:0]        MAX_COLS_C = 8'(MAX_COLS);
    localparam logic [8:0]        MAX_ROWS_C = 9'(MAX_ROWS);

    // configuration
    logic [6:0] rows_used_reg;
    logic [7:0] cols_used_reg;
    logic [7:0] eff_cols;

    // control
    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  sweep_reg;
    logic               accept;
    cmd_t               cmd_dec;
    logic               write_ok;
    logic               diff_go;

    // clear style
    logic [31:0] clr_fg_reg;
    logic [31:0] clr_bg_reg;
    logic [15:0] clr_attr_reg;
    cell_t       clear_cell;

    // snapshot write-behind
    logic              snap_wr_valid_reg;
    logic [ADDR_W-1:0] snap_wr_addr_reg;

    // row diff
    logic [5:0]       diff_row_reg;
    logic [COL_W-1:0] issue_col_reg;
    logic             issue_done_reg;
    logic             issue_last;
    logic             issue;
    logic             cmp_valid_reg;
    logic [COL_W-1:0] cmp_col_reg;
    logic             cmp_last_reg;
    logic             in_run_reg;
    logic [COL_W-1:0] run_start_reg;
    logic             pend_valid_reg;
    logic [COL_W-1:0] pend_start_reg;
    logic [7:0]       pend_end_reg;
    logic             differs;
    logic             closing;
    logic             can_load;
    logic             stall;
    logic             push_pend;
    logic             flush_load;
    logic [COL_W-1:0] new_start;
    logic [7:0]       new_end;

    // output register
    logic       out_valid_reg;
    logic [5:0] out_row_reg;
    logic [6:0] out_start_reg;
    logic [7:0] out_end_reg;
    logic       out_span_valid_reg;
    logic       out_last_reg;

    // memories
    cell_t             cur_mem  [DEPTH];
    cell_t             prev_mem [DEPTH];
    cell_t             cur_rdata_reg;
    cell_t             prev_rdata_reg;
    logic              cur_we;
    logic [ADDR_W-1:0] cur_waddr;
    cell_t             cur_wdata;
    logic              cur_re;
    logic [ADDR_W-1:0] cur_raddr;
    logic              prev_we;
    logic [ADDR_W-1:0] prev_waddr;
    cell_t             prev_wdata;
    logic              prev_re;
    logic [ADDR_W-1:0] diff_raddr;

    // ---------------------------------------------------------------- config port

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg <= ROWS_USED_RESET;
            cols_used_reg <= COLS_USED_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_ROWS_USED: rows_used_reg <= pwdata[6:0];
                REG_COLS_USED: cols_used_reg <= pwdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ROWS_USED: prdata = {25'd0, rows_used_reg};
            REG_COLS_USED: prdata = {24'd0, cols_used_reg};
        endcase
    end

    assign eff_cols = (cols_used_reg < MAX_COLS_C) ? cols_used_reg : MAX_COLS_C;

    // ---------------------------------------------------------------- decode

    assign accept   = (state_reg == ST_IDLE) && command.valid;
    assign cmd_dec  = cmd_t'(command.cmd);
    assign write_ok = ({1'b0, command.row} < rows_used_reg)
                   && ({3'b000, command.row} < MAX_ROWS_C)
                   && ({1'b0, command.col} < eff_cols);
    assign diff_go  = ({1'b0, command.row} < rows_used_reg)
                   && ({3'b000, command.row} < MAX_ROWS_C)
                   && (eff_cols != 8'd0);

    assign clear_cell = '{attributes:  clr_attr_reg,
                          glyph_width: BLANK_WIDTH,
                          glyph:       BLANK_GLYPH,
                          bg_colour:   clr_bg_reg,
                          fg_colour:   clr_fg_reg};

    // ---------------------------------------------------------------- diff datapath

    assign differs    = (cur_rdata_reg != prev_rdata_reg);
    assign closing    = cmp_valid_reg && ((differs && cmp_last_reg) || (!differs && in_run_reg));
    assign can_load   = !out_valid_reg || span.ready;
    // a closed span can only move into the pending slot once the older one has left
    assign stall      = closing && pend_valid_reg && !can_load;
    assign push_pend  = closing && pend_valid_reg && can_load;
    assign issue      = (state_reg == ST_DIFF) && !issue_done_reg && !stall;
    assign issue_last = ((8'(issue_col_reg) + 8'd1) == eff_cols);
    assign flush_load = (state_reg == ST_FLUSH) && can_load;
    assign new_start  = in_run_reg ? run_start_reg : cmp_col_reg;
    assign new_end    = differs ? (8'(cmp_col_reg) + 8'd1) : 8'(cmp_col_reg);
    assign diff_raddr = {ROW_W'(diff_row_reg), issue_col_reg};

    // ---------------------------------------------------------------- state machine

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (command.valid)
                begin
                    unique case (cmd_dec)
                        CMD_WRITE:    state_next = ST_IDLE;
                        CMD_CLEAR:    state_next = ST_CLEAR;
                        CMD_SNAPSHOT: state_next = ST_SNAP;
                        CMD_DIFF:     state_next = diff_go ? ST_DIFF : ST_FLUSH;
                    endcase
                end
            end
            ST_CLEAR, ST_SNAP:
            begin
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIFF:
            begin
                if (cmp_valid_reg && cmp_last_reg && !stall)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        command.ready = 1'b0;
        cur_we        = 1'b0;
        cur_waddr     = sweep_reg;
        cur_wdata     = '0;
        cur_re        = 1'b0;
        cur_raddr     = sweep_reg;
        prev_we       = snap_wr_valid_reg;
        prev_waddr    = snap_wr_addr_reg;
        prev_wdata    = cur_rdata_reg;
        prev_re       = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                cur_we     = 1'b1;
                prev_we    = 1'b1;
                prev_waddr = sweep_reg;
                prev_wdata = '0;
            end
            ST_IDLE:
            begin
                command.ready = 1'b1;
                cur_we        = command.valid && (cmd_dec == CMD_WRITE) && write_ok;
                cur_waddr     = {ROW_W'(command.row), COL_W'(command.col)};
                cur_wdata     = '{attributes:  command.attributes,
                                  glyph_width: command.glyph_width,
                                  glyph:       command.glyph,
                                  bg_colour:   command.bg_colour,
                                  fg_colour:   command.fg_colour};
            end
            ST_CLEAR:
            begin
                cur_we    = 1'b1;
                cur_wdata = clear_cell;
            end
            ST_SNAP:
            begin
                cur_re = 1'b1;
            end
            ST_DIFF:
            begin
                cur_re    = issue;
                prev_re   = issue;
                cur_raddr = diff_raddr;
            end
            ST_FLUSH:
            begin
                command.ready = 1'b0;
            end
            default:
            begin
                command.ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------- sweep and style

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg         <= '0;
            snap_wr_valid_reg <= 1'b0;
        end
        else
        begin
            snap_wr_valid_reg <= (state_reg == ST_SNAP);
            if (accept)
            begin
                sweep_reg <= '0;
            end
            else if ((state_reg == ST_INIT) || (state_reg == ST_CLEAR)
                     || (state_reg == ST_SNAP))
            begin
                sweep_reg <= sweep_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        snap_wr_addr_reg <= sweep_reg;
        if (accept && (cmd_dec == CMD_CLEAR))
        begin
            clr_fg_reg   <= command.fg_colour;
            clr_bg_reg   <= command.bg_colour;
            clr_attr_reg <= command.attributes;
        end
    end

    // ---------------------------------------------------------------- diff walk

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_done_reg <= 1'b1;
            cmp_valid_reg  <= 1'b0;
            in_run_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            issue_done_reg <= 1'b0;
            cmp_valid_reg  <= 1'b0;
            in_run_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                cmp_valid_reg <= 1'b1;
                if (issue_last)
                begin
                    issue_done_reg <= 1'b1;
                end
            end
            else if (!stall)
            begin
                cmp_valid_reg <= 1'b0;
            end
            if (cmp_valid_reg && !stall)
            begin
                if (closing)
                begin
                    in_run_reg     <= 1'b0;
                    pend_valid_reg <= 1'b1;
                end
                else if (differs && !in_run_reg)
                begin
                    in_run_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            diff_row_reg  <= command.row;
            issue_col_reg <= '0;
        end
        else if (issue)
        begin
            issue_col_reg <= issue_col_reg + 1'b1;
        end
        if (issue)
        begin
            cmp_col_reg  <= issue_col_reg;
            cmp_last_reg <= issue_last;
        end
        if (cmp_valid_reg && !stall)
        begin
            if (closing)
            begin
                pend_start_reg <= new_start;
                pend_end_reg   <= new_end;
            end
            else if (differs && !in_run_reg)
            begin
                run_start_reg <= cmp_col_reg;
            end
        end
    end

    // ---------------------------------------------------------------- output register

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push_pend || flush_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (span.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_pend)
        begin
            out_row_reg        <= diff_row_reg;
            out_start_reg      <= 7'(pend_start_reg);
            out_end_reg        <= pend_end_reg;
            out_span_valid_reg <= 1'b1;
            out_last_reg       <= 1'b0;
        end
        else if (flush_load)
        begin
            // row with no change reports one empty word
            out_row_reg        <= diff_row_reg;
            out_start_reg      <= pend_valid_reg ? 7'(pend_start_reg) : 7'd0;
            out_end_reg        <= pend_valid_reg ? pend_end_reg : 8'd0;
            out_span_valid_reg <= pend_valid_reg;
            out_last_reg       <= 1'b1;
        end
    end

    assign span.valid      = out_valid_reg;
    assign span.span_row   = out_row_reg;
    assign span.span_start = out_start_reg;
    assign span.span_end   = out_end_reg;
    assign span.span_valid = out_span_valid_reg;
    assign span.last       = out_last_reg;

    // ---------------------------------------------------------------- frame memories

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        if (cur_re)
        begin
            cur_rdata_reg <= cur_mem[cur_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (prev_re)
        begin
            prev_rdata_reg <= prev_mem[diff_raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/sdsd_checker.sv
// port-level checks for the screen dirty span diff block
`default_nettype none

module sdsd_port_checks (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic [1:0] cmd,
    input logic       out_valid,
    input logic       out_ready,
    input logic [6:0] span_start,
    input logic [7:0] span_end,
    input logic       span_valid,
    input logic       last
);

    import sdsd_pkg::*;

    // after a cell write the block is ready again in the next cycle
    a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd == CMD_WRITE) |=> cmd_ready)
        else $error("cell write did not return to ready");

    // every other command leaves the block busy once it has been accepted
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd != CMD_WRITE) |=> !cmd_ready)
        else $error("ready stayed high after a sweep or diff command");

    // an empty word closes the diff and carries a zero span
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !span_valid |-> last && (span_start == 7'd0) && (span_end == 8'd0))
        else $error("empty span word malformed");

    // a reported span is never empty
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && span_valid |-> (span_end > {1'b0, span_start}))
        else $error("span end not beyond span start");

    // a word held back keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({span_start, span_end, span_valid, last}))
        else $error("span word changed while stalled");

endmodule

bind screen_dirty_span_diff sdsd_port_checks u_sdsd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (command.valid),
    .cmd_ready  (command.ready),
    .cmd        (command.cmd),
    .out_valid  (span.valid),
    .out_ready  (span.ready),
    .span_start (span.span_start),
    .span_end   (span.span_end),
    .span_valid (span.span_valid),
    .last       (span.last)
);

`default_nettype wire
